@@ sv/fcsc_pkg.sv @@
// Shared types and constants for the finite-context symbol counter.
package fcsc_pkg;

  localparam int NUM_SYMBOLS = 4;
  localparam int SYM_W       = 2;
  localparam int FREQ_W      = 24;
  localparam int TOTAL_W     = 26;
  localparam int ORDER_W     = 4;
  localparam int ALPHA_W     = 8;
  localparam int LIMIT_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int OCC_W       = 4;

  localparam logic [ORDER_W-1:0] ORDER_RST = 4'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 8'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'hFFFF;
  localparam logic [FREQ_W-1:0]  FREQ_MAX  = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER = 2'd0,
    CFG_ALPHA = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  freq_sym0;
    logic [FREQ_W-1:0]  freq_sym1;
    logic [FREQ_W-1:0]  freq_sym2;
    logic [FREQ_W-1:0]  freq_sym3;
    logic [TOTAL_W-1:0] freq_total;
  } freq_res_t;

  typedef struct packed {
    logic upd_vld;
    logic prod_vld;
  } upd_status_t;

endpackage

@@ sv/fcsc_sym_if.sv @@
// Input channel interface: one symbol per transaction.
interface fcsc_sym_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

@@ sv/fcsc_freq_if.sv @@
// Result channel interface: four symbol frequencies and their sum per transaction.
interface fcsc_freq_if;
  logic        valid;
  logic        ready;
  logic [23:0] freq_sym0;
  logic [23:0] freq_sym1;
  logic [23:0] freq_sym2;
  logic [23:0] freq_sym3;
  logic [25:0] freq_total;

  modport source (output valid, output freq_sym0, output freq_sym1, output freq_sym2,
                  output freq_sym3, output freq_total, input ready);
  modport sink (input valid, input freq_sym0, input freq_sym1, input freq_sym2,
                input freq_sym3, input freq_total, output ready);
endinterface

@@ sv/fcsc_count_ram.sv @@
// Counter store: single-port-write, single-port-read synchronous memory.
module fcsc_count_ram #(
  parameter int ADDR_W = 20,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              re,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/fcsc_update.sv @@
// Read-modify-write stage: forwarding, counter increment and halving, count scaling.
module fcsc_update
  import fcsc_pkg::*;
#(
  parameter int ADDR_W     = 20,
  parameter int COUNT_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      issue_vld,
  input  logic [ADDR_W-1:0]                         issue_addr,
  input  logic [SYM_W-1:0]                          issue_sym,
  input  logic [NUM_SYMBOLS*COUNT_BITS-1:0]         rd_data,
  input  logic [ALPHA_W-1:0]                        alpha,
  input  logic [LIMIT_W-1:0]                        count_limit,
  output logic                                      wr_en,
  output logic [ADDR_W-1:0]                         wr_addr,
  output logic [NUM_SYMBOLS*COUNT_BITS-1:0]         wr_data,
  output logic [NUM_SYMBOLS-1:0][ALPHA_W+COUNT_BITS-1:0] prod,
  output upd_status_t                               status
);

  localparam int WORD_W = NUM_SYMBOLS * COUNT_BITS;
  localparam int PROD_W = ALPHA_W + COUNT_BITS;
  localparam int CMP_W  = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic                                   upd_vld_r;
  logic [ADDR_W-1:0]                      upd_addr_r;
  logic [SYM_W-1:0]                       upd_sym_r;
  logic                                   fwd_hit_r;
  logic [WORD_W-1:0]                      fwd_data_r;
  logic                                   prod_vld_r;
  logic [NUM_SYMBOLS-1:0][PROD_W-1:0]     prod_r;
  logic [NUM_SYMBOLS-1:0][COUNT_BITS-1:0] cnt;
  logic [NUM_SYMBOLS-1:0][COUNT_BITS-1:0] cnt_new;
  logic [COUNT_BITS-1:0]                  inc;
  logic                                   halve;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_vld_r  <= 1'b0;
      fwd_hit_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      upd_vld_r  <= issue_vld;
      // The write of the previous item lands on the same edge as this read,
      // so the memory returns stale data; keep the written word instead.
      fwd_hit_r  <= issue_vld && wr_en && (wr_addr == issue_addr);
      prod_vld_r <= upd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    upd_addr_r <= issue_addr;
    upd_sym_r  <= issue_sym;
    fwd_data_r <= wr_data;
    for (int j = 0; j < NUM_SYMBOLS; j++) begin
      prod_r[j] <= PROD_W'(alpha) * PROD_W'(cnt[j]);
    end
  end

  always_comb begin
    cnt   = fwd_hit_r ? fwd_data_r : rd_data;
    inc   = cnt[upd_sym_r] + COUNT_BITS'(1);
    halve = (CMP_W'(inc) == CMP_W'(count_limit)) || (inc == '1);
    for (int j = 0; j < NUM_SYMBOLS; j++) begin
      cnt_new[j] = (SYM_W'(j) == upd_sym_r) ? inc : cnt[j];
      if (halve) begin
        cnt_new[j] = cnt_new[j] >> 1;
      end
    end
  end

  assign wr_en           = upd_vld_r;
  assign wr_addr         = upd_addr_r;
  assign wr_data         = cnt_new;
  assign prod            = prod_r;
  assign status.upd_vld  = upd_vld_r;
  assign status.prod_vld = prod_vld_r;

`ifndef SYNTH
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> upd_vld_r)
    else $error("forwarded word with no item in the update stage");
`endif

endmodule

@@ sv/fcsc_result_queue.sv @@
// Frequency finishing (offset, saturation, sum) and the output queue.
module fcsc_result_queue
  import fcsc_pkg::*;
#(
  parameter int PROD_W = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              prod_vld,
  input  logic [NUM_SYMBOLS-1:0][PROD_W-1:0] prod,
  output logic [QPTR_W:0]                   count,
  fcsc_freq_if.source                       out_freq
);

  localparam int SUM_W = ((PROD_W + 1) > (FREQ_W + 1)) ? (PROD_W + 1) : (FREQ_W + 1);

  freq_res_t                          q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]                  wr_ptr_r;
  logic [QPTR_W-1:0]                  rd_ptr_r;
  logic [QPTR_W:0]                    cnt_r;
  logic [NUM_SYMBOLS-1:0][SUM_W-1:0]  fsum;
  logic [NUM_SYMBOLS-1:0][FREQ_W-1:0] freq;
  logic [TOTAL_W-1:0]                 total;
  freq_res_t                          res;
  freq_res_t                          head;
  logic                               push;
  logic                               pop;

  always_comb begin
    total = '0;
    for (int j = 0; j < NUM_SYMBOLS; j++) begin
      fsum[j] = SUM_W'(prod[j]) + SUM_W'(1);
      freq[j] = (fsum[j] > SUM_W'(FREQ_MAX)) ? FREQ_MAX : fsum[j][FREQ_W-1:0];
      total   = total + TOTAL_W'(freq[j]);
    end
    res.freq_sym0  = freq[0];
    res.freq_sym1  = freq[1];
    res.freq_sym2  = freq[2];
    res.freq_sym3  = freq[3];
    res.freq_total = total;
  end

  assign push = prod_vld;
  assign pop  = out_freq.valid && out_freq.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= res;
    end
  end

  assign head                = q_mem_r[rd_ptr_r];
  assign count               = cnt_r;
  assign out_freq.valid      = (cnt_r != '0);
  assign out_freq.freq_sym0  = head.freq_sym0;
  assign out_freq.freq_sym1  = head.freq_sym1;
  assign out_freq.freq_sym2  = head.freq_sym2;
  assign out_freq.freq_sym3  = head.freq_sym3;
  assign out_freq.freq_total = head.freq_total;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (QPTR_W+1)'(QUEUE_DEPTH) || pop))
    else $error("result queue written while full");
`endif

endmodule

@@ sv/finite_context_symbol_counter_core.sv @@
// Top level of the finite-context symbol counter: configuration, context and clearing sweep.
// After reset the block zeroes its counter memory, one context word per cycle, over all
// 4**MAX_ORDER words (1,048,576 at the default MAX_ORDER of 10) and holds in_sym.ready low
// meanwhile; configuration writes are taken at any time. It then takes one symbol per
// cycle. Each symbol's result is registered first by the counter memory read, then by the
// counter update with the alpha products, then by the frequency sum into a four-entry
// output queue. The counter memory has one read and one write port; a symbol whose
// context word is still being written by the symbol just before it gets that word
// forwarded, so repeated contexts run at full rate. in_sym.ready drops only when the
// output queue and the two stages in flight would exceed four results.
module finite_context_symbol_counter_core
  import fcsc_pkg::*;
#(
  parameter int MAX_ORDER  = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fcsc_sym_if.sink              in_sym,
  fcsc_freq_if.source           out_freq,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CTX_W  = 2 * MAX_ORDER;
  localparam int WORD_W = NUM_SYMBOLS * COUNT_BITS;
  localparam int PROD_W = ALPHA_W + COUNT_BITS;

  logic [ORDER_W-1:0]                 order_r;
  logic [ALPHA_W-1:0]                 alpha_r;
  logic [LIMIT_W-1:0]                 limit_r;
  logic [CTX_W-1:0]                   ctx_r;
  logic                               clr_active_r;
  logic [CTX_W-1:0]                   clr_addr_r;
  logic [ORDER_W-1:0]                 order_eff;
  logic [CTX_W-1:0]                   ctx_mask;
  logic [CTX_W-1:0]                   rd_addr;
  logic [CTX_W-1:0]                   ctx_nxt;
  logic                               accept;
  logic                               upd_wr_en;
  logic [CTX_W-1:0]                   upd_wr_addr;
  logic [WORD_W-1:0]                  upd_wr_data;
  logic                               ram_we;
  logic [CTX_W-1:0]                   ram_wr_addr;
  logic [WORD_W-1:0]                  ram_wr_data;
  logic [WORD_W-1:0]                  ram_rd_data;
  logic [NUM_SYMBOLS-1:0][PROD_W-1:0] prod;
  upd_status_t                        upd_status;
  logic [QPTR_W:0]                    q_count;
  logic [OCC_W-1:0]                   occupancy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RST;
      alpha_r <= ALPHA_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER: order_r <= cfg_wdata[ORDER_W-1:0];
        CFG_ALPHA: alpha_r <= cfg_wdata[ALPHA_W-1:0];
        CFG_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // An order of zero acts as one; orders past MAX_ORDER act as MAX_ORDER.
  always_comb begin
    if (order_r == '0) begin
      order_eff = ORDER_W'(1);
    end else if (order_r > ORDER_W'(MAX_ORDER)) begin
      order_eff = ORDER_W'(MAX_ORDER);
    end else begin
      order_eff = order_r;
    end
    for (int i = 0; i < CTX_W; i++) begin
      ctx_mask[i] = (ORDER_W'(i / 2) < order_eff);
    end
  end

  assign accept  = in_sym.valid && in_sym.ready;
  assign rd_addr = ctx_r & ctx_mask;
  assign ctx_nxt = CTX_W'({rd_addr, in_sym.symbol}) & ctx_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else if (accept) begin
      ctx_r <= ctx_nxt;
    end
  end

  // Clearing sweep over the whole counter memory after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + CTX_W'(1);
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign occupancy = OCC_W'(q_count) + OCC_W'(upd_status.upd_vld) + OCC_W'(upd_status.prod_vld);
  assign in_sym.ready = !clr_active_r && (occupancy < OCC_W'(QUEUE_DEPTH));

  assign ram_we      = clr_active_r || upd_wr_en;
  assign ram_wr_addr = clr_active_r ? clr_addr_r : upd_wr_addr;
  assign ram_wr_data = clr_active_r ? '0 : upd_wr_data;

  fcsc_count_ram #(
    .ADDR_W(CTX_W),
    .DATA_W(WORD_W)
  ) u_count_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .re     (accept),
    .rd_addr(rd_addr),
    .rd_data(ram_rd_data)
  );

  fcsc_update #(
    .ADDR_W    (CTX_W),
    .COUNT_BITS(COUNT_BITS)
  ) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue_vld  (accept),
    .issue_addr (rd_addr),
    .issue_sym  (in_sym.symbol),
    .rd_data    (ram_rd_data),
    .alpha      (alpha_r),
    .count_limit(limit_r),
    .wr_en      (upd_wr_en),
    .wr_addr    (upd_wr_addr),
    .wr_data    (upd_wr_data),
    .prod       (prod),
    .status     (upd_status)
  );

  fcsc_result_queue #(
    .PROD_W(PROD_W)
  ) u_result_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .prod_vld(upd_status.prod_vld),
    .prod    (prod),
    .count   (q_count),
    .out_freq(out_freq)
  );

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !clr_active_r)
    else $error("symbol taken during the clearing sweep");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= OCC_W'(QUEUE_DEPTH))
    else $error("more results in flight than the output queue can hold");

  a_update_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> upd_status.upd_vld)
    else $error("accepted symbol did not reach the update stage");
`endif

endmodule

@@ tb/fcsc_freq_checker.sv @@
// Checker for the finite-context symbol counter: predicts every frequency result and compares it.
`timescale 1ns / 100ps
module fcsc_freq_checker
  import fcsc_pkg::*;
#(
  parameter int MAX_ORDER  = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fcsc_sym_if                   sym_mon,
  fcsc_freq_if                  freq_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    error_count,
  output int                    results_pending
);

  localparam int CTX_W = 2 * MAX_ORDER;
  localparam int unsigned COUNT_TOP = 32'((64'd1 << COUNT_BITS) - 1);

  typedef logic [NUM_SYMBOLS-1:0][COUNT_BITS-1:0] ctx_counts_t;

  // Only contexts that were ever touched are kept; all others read as zero.
  ctx_counts_t        count_mem [int unsigned];
  logic [CTX_W-1:0]   context_q;
  logic [ORDER_W-1:0] order_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [LIMIT_W-1:0] limit_q;
  freq_res_t          pending_freqs [$];

  task automatic predict_context_freqs(input logic [SYM_W-1:0] sym);
    int unsigned order_eff;
    int unsigned ctx_mask;
    int unsigned ctx;
    int unsigned s;
    int unsigned f;
    int unsigned total;
    int unsigned v;
    logic [FREQ_W-1:0] freqs [NUM_SYMBOLS];
    ctx_counts_t cnt;
    freq_res_t res;
    order_eff = (order_q == 0) ? 1 : (order_q > MAX_ORDER) ? MAX_ORDER : order_q;
    ctx_mask = (32'd1 << (2 * order_eff)) - 1;
    ctx = context_q & ctx_mask;
    s = sym;
    cnt = count_mem.exists(ctx) ? count_mem[ctx] : '0;
    total = 0;
    for (int j = 0; j < NUM_SYMBOLS; j++) begin
      f = 1 + alpha_q * cnt[j];
      if (f > FREQ_MAX) f = FREQ_MAX;
      freqs[j] = f[FREQ_W-1:0];
      total += f;
    end
    res.freq_sym0  = freqs[0];
    res.freq_sym1  = freqs[1];
    res.freq_sym2  = freqs[2];
    res.freq_sym3  = freqs[3];
    res.freq_total = total[TOTAL_W-1:0];
    pending_freqs.push_back(res);

    // The counters saturate by halving, either at the programmed limit or at all ones.
    v = (cnt[s] + 1) & COUNT_TOP;
    cnt[s] = v[COUNT_BITS-1:0];
    if (v == limit_q || v == COUNT_TOP) begin
      for (int j = 0; j < NUM_SYMBOLS; j++) cnt[j] = cnt[j] >> 1;
    end
    count_mem[ctx] = cnt;
    context_q = CTX_W'((ctx * NUM_SYMBOLS + s) & ctx_mask);
  endtask

  task automatic check_freqs();
    freq_res_t seen;
    freq_res_t want;
    logic [4:0] bad;
    seen.freq_sym0  = freq_mon.freq_sym0;
    seen.freq_sym1  = freq_mon.freq_sym1;
    seen.freq_sym2  = freq_mon.freq_sym2;
    seen.freq_sym3  = freq_mon.freq_sym3;
    seen.freq_total = freq_mon.freq_total;
    if (pending_freqs.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: result transaction with nothing predicted: %h %h %h %h total %h",
                 $time, seen.freq_sym0, seen.freq_sym1, seen.freq_sym2, seen.freq_sym3,
                 seen.freq_total);
    end else begin
      want = pending_freqs.pop_front();
      bad = {seen.freq_sym0 !== want.freq_sym0, seen.freq_sym1 !== want.freq_sym1,
             seen.freq_sym2 !== want.freq_sym2, seen.freq_sym3 !== want.freq_sym3,
             seen.freq_total !== want.freq_total};
      if (bad != 0) begin
        error_count++;
        if (error_count <= 10)
          $display({"%0t: frequency mismatch (fields sym0..total %b): ",
                    "expected %h %h %h %h total %h, got %h %h %h %h total %h"},
                   $time, bad, want.freq_sym0, want.freq_sym1, want.freq_sym2,
                   want.freq_sym3, want.freq_total, seen.freq_sym0, seen.freq_sym1,
                   seen.freq_sym2, seen.freq_sym3, seen.freq_total);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      count_mem.delete();
      pending_freqs.delete();
      context_q = '0;
      order_q   = ORDER_RST;
      alpha_q   = ALPHA_RST;
      limit_q   = LIMIT_RST;
    end else begin
      if (freq_mon.valid && freq_mon.ready) check_freqs();
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORDER: order_q = cfg_wdata[ORDER_W-1:0];
          CFG_ALPHA: alpha_q = cfg_wdata[ALPHA_W-1:0];
          CFG_LIMIT: limit_q = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (sym_mon.valid && sym_mon.ready) predict_context_freqs(sym_mon.symbol);
    end
    results_pending = pending_freqs.size();
  end

endmodule

@@ tb/finite_context_symbol_counter_core_tb.sv @@
// Top of the testbench: clock, reset, symbol and configuration stimulus, and the verdict.
`timescale 1ns / 100ps
module finite_context_symbol_counter_core_tb
  import fcsc_pkg::*;
();

  // The limit leaves ample room beyond the clearing sweep over all 4**10 context words.
  localparam int CYCLE_LIMIT    = 4_000_000;
  localparam int BLOCK_ITEMS    = 63;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register lives at this index

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    error_count;
  int                    results_pending;
  int unsigned           src_idle_pct;
  int unsigned           sink_idle_pct;
  int                    cycle_count = 0;

  fcsc_sym_if  sym_ch ();
  fcsc_freq_if freq_ch ();

  finite_context_symbol_counter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sym    (sym_ch),
    .out_freq  (freq_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fcsc_freq_checker freq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .sym_mon         (sym_ch),
    .freq_mon        (freq_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    freq_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** finite_context_symbol_counter_core: FAILED **");
      $finish;
    end
  end

  // Leaves valid high after the transaction; the next call or a drain decides what follows.
  task automatic send_symbol(input logic [SYM_W-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= s;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
  endtask

  // Sampling at the falling edge keeps the count clear of the checker's rising-edge update.
  task automatic drain_results();
    sym_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Bits above each register's width carry random data and must be dropped by the block.
  task automatic set_config(input logic [ORDER_W-1:0] order, input logic [ALPHA_W-1:0] alpha,
                            input logic [LIMIT_W-1:0] limit);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = CFG_DATA_W'($urandom());
    wdata[ORDER_W-1:0] = order;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ORDER;
    cfg_wdata <= wdata;
    @(posedge clk);
    wdata = CFG_DATA_W'($urandom());
    wdata[ALPHA_W-1:0] = alpha;
    cfg_index <= CFG_ALPHA;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= CFG_DATA_W'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [ORDER_W-1:0] order;
    logic [ALPHA_W-1:0] alpha;
    logic [LIMIT_W-1:0] limit;
    case ($urandom_range(0, 7))
      0, 1, 2: order = ORDER_W'($urandom_range(1, 3));
      3:       order = '0;
      4:       order = ORDER_W'($urandom_range(11, 15));
      default: order = ORDER_W'($urandom_range(1, 10));
    endcase
    case ($urandom_range(0, 5))
      0:       alpha = '0;
      1:       alpha = '1;
      2:       alpha = 8'd1;
      default: alpha = ALPHA_W'($urandom());
    endcase
    // Small limits make halving frequent enough to matter.
    case ($urandom_range(0, 7))
      0:       limit = '0;
      1:       limit = 16'd1;
      2:       limit = 16'd2;
      3:       limit = '1;
      4, 5:    limit = LIMIT_W'($urandom_range(3, 12));
      6:       limit = LIMIT_W'($urandom_range(13, 300));
      default: limit = LIMIT_W'($urandom());
    endcase
    set_config(order, alpha, limit);
  endtask

  // Runs of repeated symbols and short periodic patterns revisit the same contexts back to
  // back, which is where counter forwarding and halving happen.
  task automatic send_random_block(input int unsigned n_items, input int unsigned phase_src,
                                   input int unsigned phase_sink);
    int unsigned sent;
    int unsigned run_len;
    int unsigned mode;
    int unsigned period;
    logic [SYM_W-1:0] pattern [4];
    logic [SYM_W-1:0] pick;
    sent = 0;
    while (sent < n_items) begin
      run_len = $urandom_range(6, 30);
      mode    = $urandom_range(0, 3);
      period  = $urandom_range(1, 4);
      foreach (pattern[k]) pattern[k] = SYM_W'($urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) begin
        src_idle_pct   = 0;
        sink_idle_pct <= 0;
      end else begin
        src_idle_pct   = phase_src;
        sink_idle_pct <= phase_sink;
      end
      for (int unsigned i = 0; i < run_len && sent < n_items; i++) begin
        case (mode)
          0:       pick = SYM_W'($urandom_range(0, 3));
          1:       pick = pattern[0];
          2:       pick = pattern[i % period];
          default: pick = ($urandom_range(0, 3) != 0) ? pattern[0]
                                                      : SYM_W'($urandom_range(0, 3));
        endcase
        send_symbol(pick);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned src_pct [3];
    int unsigned sink_pct [3];
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ORDER;
    cfg_wdata     = '0;
    sym_ch.valid  = 1'b0;
    sym_ch.symbol = '0;
    freq_ch.ready = 1'b0;
    src_idle_pct  = 13;
    sink_idle_pct = 57;
    src_pct  = '{13, 57, 0};
    sink_pct = '{57, 13, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings first; the block holds off symbols until its clearing sweep is done.
    send_symbol(2'd0);
    send_symbol(2'd1);
    send_symbol(2'd2);
    send_symbol(2'd3);
    send_symbol(2'd0);

    // Order zero behaves as order one; a limit of two halves on the second hit.
    drain_results();
    set_config(4'd0, 8'd255, 16'd2);
    send_symbol(2'd0);
    send_symbol(2'd0);
    send_symbol(2'd0);
    send_symbol(2'd1);
    send_symbol(2'd2);
    send_symbol(2'd3);
    send_symbol(2'd3);
    send_symbol(2'd3);

    // Order above the maximum is clamped; alpha zero flattens all frequencies to one.
    drain_results();
    set_config(4'd15, 8'd0, 16'd1);
    send_symbol(2'd3);
    send_symbol(2'd2);
    send_symbol(2'd1);
    send_symbol(2'd0);
    send_symbol(2'd0);

    // Order is set to the maximum again, without clearing the counters.
    drain_results();
    set_config(4'd10, 8'd128, 16'd3);
    send_symbol(2'd2);
    send_symbol(2'd2);
    send_symbol(2'd2);
    send_symbol(2'd2);
    send_symbol(2'd1);
    send_symbol(2'd1);

    for (int p = 0; p < 3; p++) begin
      for (int blk = 0; blk < 4; blk++) begin
        drain_results();
        random_config();
        send_random_block(BLOCK_ITEMS, src_pct[p], sink_pct[p]);
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("** finite_context_symbol_counter_core: PASSED **");
    end else begin
      $display("** finite_context_symbol_counter_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/fcsc_pkg.sv
sv/fcsc_sym_if.sv
sv/fcsc_freq_if.sv
sv/fcsc_count_ram.sv
sv/fcsc_update.sv
sv/fcsc_result_queue.sv
sv/finite_context_symbol_counter_core.sv
tb/fcsc_freq_checker.sv
tb/finite_context_symbol_counter_core_tb.sv
